// ===== hdl/gain_matrix_vector_mixer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Gain matrix mixer assertion macros
// Shared forms for the concurrent checks of the mixer core. Each macro uses
// the enclosing module's clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef GAIN_MATRIX_VECTOR_MIXER_CORE_ASSERT_SVH
`define GAIN_MATRIX_VECTOR_MIXER_CORE_ASSERT_SVH

// same-cycle implication
`define GMVM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmvm check failed");

// next-cycle implication
`define GMVM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmvm check failed");

`endif

// ===== hdl/gmvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Gain matrix mixer package
// Sizes, widths and the control bundle shared by the mixer core and its MAC.
// ----------------------------------------------------------------------------
`default_nettype none

package gmvm_pkg;

    localparam int MAX_IN_CHANNELS  = 128;
    localparam int MAX_OUT_CHANNELS = 64;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 32;
    localparam int MODE_W    = 2;
    localparam int N_W       = $clog2(MAX_IN_CHANNELS + 1);    // in_channels field
    localparam int M_W       = $clog2(MAX_OUT_CHANNELS + 1);   // out_channels field
    localparam int IDX_W     = $clog2(MAX_IN_CHANNELS);        // store address
    localparam int ROW_W     = $clog2(MAX_OUT_CHANNELS);       // output channel
    localparam int FLAT_W    = $clog2(MAX_IN_CHANNELS * MAX_OUT_CHANNELS);
    localparam int CFG_IDX_W = 2;

    localparam int ACC_W  = SAMPLE_W + IDX_W;
    localparam int PROD_W = ACC_W + GAIN_W;
    localparam int Q_FRAC = 16;
    localparam int QV_W   = PROD_W - Q_FRAC;

    localparam int Q_BIAS  = (1 << Q_FRAC) - 1;
    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    typedef struct packed {
        logic clear;   // zero the accumulator
        logic add;     // add the read sample
        logic mul;     // register acc * gain
        logic rnd;     // scale, saturate, load result
    } gmvm_mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/gmvm_mac.sv =====
// ----------------------------------------------------------------------------
// Gain matrix mixer MAC
// Shared accumulator, gain multiply and truncating Q16 scale with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gmvm_mac
    import gmvm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gmvm_mac_ctrl_t             ctrl,
    input  wire logic signed [SAMPLE_W-1:0] rd_sample,
    input  wire logic signed [GAIN_W-1:0]   gain,
    output logic signed [SAMPLE_W-1:0]      value,
    output logic                            clip
);

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   bias;
    logic signed [PROD_W-1:0]   biased;
    logic signed [QV_W-1:0]     quot;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       clip_reg;
    logic                       clip_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.add)
        begin
            acc_next = acc_reg + ACC_W'(rd_sample);
        end
    end

    assign prod_next = acc_reg * gain;

    // truncate toward zero: bias negatives by 2^16-1 before the shift
    assign bias   = prod_reg[PROD_W-1] ? PROD_W'(Q_BIAS) : '0;
    assign biased = prod_reg + bias;
    assign quot   = $signed(biased[PROD_W-1:Q_FRAC]);

    always_comb
    begin
        if (quot > QV_W'(OUT_MAX))
        begin
            value_next = SAMPLE_W'(OUT_MAX);
            clip_next  = 1'b1;
        end
        else if (quot < QV_W'(OUT_MIN))
        begin
            value_next = SAMPLE_W'(OUT_MIN);
            clip_next  = 1'b1;
        end
        else
        begin
            value_next = quot[SAMPLE_W-1:0];
            clip_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.rnd)
        begin
            value_reg <= value_next;
            clip_reg  <= clip_next;
        end
    end

    assign value = value_reg;
    assign clip  = clip_reg;

endmodule

`default_nettype wire

// ===== hdl/gain_matrix_vector_mixer_core.sv =====
// ----------------------------------------------------------------------------
// Gain matrix mixer core
// Collects a vector of signed samples, then emits one saturated gain-scaled
// sum per output channel over a fixed matrix pattern picked by mode.
//
//   channel  dir  handshake           payload
//   cfg      in   cfg_we              cfg_index, cfg_data
//   input    in   in_valid/in_stall   sample
//   output   out  out_valid/out_stall out_value, out_channel, clipped,
//                                     last_of_vector
//
// - While collecting, one sample beat is taken every cycle (in_stall low).
// - The beat that completes the vector starts the mix: per output row the
//   single accumulator walks all N stored samples, then tail add,
//   multiply and scale follow; the row then waits in the output beat.
//   in_stall is high throughout, also while output stalls hold a row.
// - Reset clears configuration to defaults and the fill count; the sample
//   store is not cleared.
// - out_stall only holds the current result beat; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gain_matrix_vector_mixer_core_assert.svh"

module gain_matrix_vector_mixer_core
    import gmvm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [GAIN_W-1:0]          cfg_data,
    // input samples
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    // results
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [SAMPLE_W-1:0]      out_value,
    output logic [ROW_W-1:0]                out_channel,
    output logic                            clipped,
    output logic                            last_of_vector
);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CH  = 2'd3;

    // matrix patterns
    localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIAG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MULTI = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HALF  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_MUL,
        ST_RND,
        ST_EMIT
    } state_t;

    // ---------------- configuration registers ----------------
    logic [MODE_W-1:0]        mode_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    logic [N_W-1:0]           in_ch_reg;
    logic [M_W-1:0]           out_ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ZERO;
            gain_reg   <= GAIN_W'(65536);
            in_ch_reg  <= N_W'(MAX_IN_CHANNELS);
            out_ch_reg <= M_W'(MAX_OUT_CHANNELS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_GAIN:   gain_reg   <= $signed(cfg_data);
                CFG_IN_CH:  in_ch_reg  <= cfg_data[N_W-1:0];
                CFG_OUT_CH: out_ch_reg <= cfg_data[M_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // effective counts: zero acts as one, clamp to the store sizes
    logic [N_W-1:0]   n_eff;
    logic [M_W-1:0]   m_eff;
    logic [M_W-2:0]   stride;

    always_comb
    begin
        if (in_ch_reg == '0)
            n_eff = N_W'(1);
        else if (in_ch_reg > N_W'(MAX_IN_CHANNELS))
            n_eff = N_W'(MAX_IN_CHANNELS);
        else
            n_eff = in_ch_reg;

        if (out_ch_reg == '0)
            m_eff = M_W'(1);
        else if (out_ch_reg > M_W'(MAX_OUT_CHANNELS))
            m_eff = M_W'(MAX_OUT_CHANNELS);
        else
            m_eff = out_ch_reg;
    end

    assign stride = m_eff[M_W-1:1];

    // ---------------- sequencer ----------------
    state_t                     state_reg, state_next;
    logic [N_W-1:0]             fill_reg, fill_next;
    logic [ROW_W-1:0]           j_reg, j_next;
    logic [IDX_W-1:0]           ai_reg, ai_next;
    logic [N_W-1:0]             r_reg, r_next;       // (j*N + ai) mod (N+1)
    logic [N_W-1:0]             off_reg, off_next;   // next diagonal residue
    logic [N_W:0]               dm_reg, dm_next;     // d * M of that residue
    logic                       done_reg, done_next; // no residues left this pass
    logic                       add_en_reg, add_en_next;
    logic                       set_d_reg, set_d_next;
    logic                       last_reg, last_next;

    logic                       in_acc;
    logic                       out_acc;
    logic [N_W-1:0]             fill_plus;
    logic                       ai_last;
    logic                       j_last;
    logic                       act;
    logic [N_W:0]               dm_sum;
    logic                       set_now;
    gmvm_mac_ctrl_t             mac_ctrl;

    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;
    assign fill_plus = fill_reg + N_W'(1);
    assign ai_last   = ({1'b0, ai_reg} == (n_eff - N_W'(1)));
    assign j_last    = ({1'b0, j_reg} == (m_eff - M_W'(1)));

    // diagonal offsets d*stride all lie below N+1, so each is its own
    // residue; one pointer walks them in order on every residue pass
    assign act    = !done_reg && (r_reg == off_reg);
    assign dm_sum = dm_reg + (N_W+1)'(m_eff);

    always_comb
    begin
        case (mode_reg)
            MODE_DIAG:  set_now = (r_reg == '0);
            MODE_MULTI: set_now = act;
            MODE_HALF:  set_now = ({1'b0, ai_reg} < (n_eff >> 1));
            default:    set_now = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        j_next      = j_reg;
        ai_next     = ai_reg;
        r_next      = r_reg;
        off_next    = off_reg;
        dm_next     = dm_reg;
        done_next   = done_reg;
        add_en_next = 1'b0;
        set_d_next  = set_d_reg;
        last_next   = last_reg;
        mac_ctrl    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (fill_plus >= n_eff)
                    begin
                        fill_next      = '0;
                        state_next     = ST_SCAN;
                        j_next         = '0;
                        ai_next        = '0;
                        r_next         = '0;
                        off_next       = '0;
                        dm_next        = '0;
                        done_next      = 1'b0;
                        mac_ctrl.clear = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_plus;
                    end
                end
            end
            ST_SCAN:
            begin
                add_en_next = 1'b1;
                set_d_next  = set_now;
                r_next      = (r_reg == n_eff) ? '0 : r_reg + N_W'(1);
                if (act)
                begin
                    off_next        = off_reg + N_W'(stride);
                    dm_next         = dm_sum;
                    done_next       = (stride == '0) || (dm_sum >= (N_W+1)'(n_eff));
                end
                // residue wraps: restart the diagonal pointer
                if (r_reg == n_eff)
                begin
                    off_next  = '0;
                    dm_next   = '0;
                    done_next = 1'b0;
                end
                if (ai_last)
                    state_next = ST_TAIL;
                else
                    ai_next = ai_reg + IDX_W'(1);
            end
            ST_TAIL:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mac_ctrl.mul = 1'b1;
                state_next   = ST_RND;
            end
            ST_RND:
            begin
                mac_ctrl.rnd = 1'b1;
                last_next    = j_last;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next         = j_reg + ROW_W'(1);
                        ai_next        = '0;
                        mac_ctrl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        mac_ctrl.add = add_en_reg && set_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            j_reg      <= '0;
            ai_reg     <= '0;
            r_reg      <= '0;
            off_reg    <= '0;
            dm_reg     <= '0;
            done_reg   <= 1'b0;
            add_en_reg <= 1'b0;
            set_d_reg  <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            j_reg      <= j_next;
            ai_reg     <= ai_next;
            r_reg      <= r_next;
            off_reg    <= off_next;
            dm_reg     <= dm_next;
            done_reg   <= done_next;
            add_en_reg <= add_en_next;
            set_d_reg  <= set_d_next;
            last_reg   <= last_next;
        end
    end

    // ---------------- sample store ----------------
    // written while collecting, read one address per cycle while scanning
    logic signed [SAMPLE_W-1:0] store_mem [MAX_IN_CHANNELS];
    logic signed [SAMPLE_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && (fill_reg < N_W'(MAX_IN_CHANNELS)))
        begin
            store_mem[fill_reg[IDX_W-1:0]] <= sample;
        end
        rd_reg <= store_mem[ai_reg];
    end

    // ---------------- shared MAC ----------------
    gmvm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .rd_sample (rd_reg),
        .gain      (gain_reg),
        .value     (out_value),
        .clip      (clipped)
    );

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = (state_reg == ST_EMIT);
    assign out_channel    = j_reg;
    assign last_of_vector = last_reg;

    // ---------------- checks ----------------
    `GMVM_ASSERT_NEXT(a_last_beat_to_idle, out_acc && last_of_vector, !in_stall)
    `GMVM_ASSERT_NEXT(a_mid_vector_busy, out_acc && !last_of_vector, in_stall && !out_valid)
    `GMVM_ASSERT_IMPL(a_scan_in_range, state_reg == ST_SCAN,
        ({1'b0, ai_reg} < n_eff) && ({1'b0, j_reg} < m_eff))
    `GMVM_ASSERT_IMPL(a_fill_bound, !in_stall, fill_reg < N_W'(MAX_IN_CHANNELS))

endmodule

`default_nettype wire

// ===== bench/tb_gain_matrix_vector_mixer_core.sv =====
// ----------------------------------------------------------------------------
// Gain matrix mixer core testbench
// Sends vectors of samples through the core under several matrix modes,
// gains and channel counts. Each result beat is checked against a local
// model of the mixer. A short table of hand-picked vectors runs first, then
// random vectors under changing back-pressure and idle profiles.
// ----------------------------------------------------------------------------
module tb_gain_matrix_vector_mixer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gmvm_pkg::*;

    // matrix patterns and register map of the config port
    typedef enum logic [MODE_W-1:0] {
        MIX_ZERO,
        MIX_DIAG,
        MIX_MULTI,
        MIX_HALF
    } mix_mode_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE,
        REG_GAIN,
        REG_IN_CH,
        REG_OUT_CH
    } reg_idx_e;

    typedef logic signed [SAMPLE_W-1:0] smp_t;

    // one result beat as the core presents it
    typedef struct packed {
        smp_t             value;
        logic [ROW_W-1:0] chan;
        logic             clip;
        logic             last;
    } mix_result_t;

    // one row of the directed table: settings, then `count` samples
    // first, first+incr, ... (16-bit wrap). Where `typed` is set every
    // result of the vector carries exp_value / exp_clip.
    typedef struct packed {
        mix_mode_e   mode;
        logic [31:0] gain;
        logic [7:0]  n_raw;
        logic [6:0]  m_raw;
        logic [7:0]  count;
        smp_t        first;
        smp_t        incr;
        logic        typed;
        smp_t        exp_value;
        logic        exp_clip;
    } mix_row_t;

    localparam int ITEMS        = 330;   // random sample beats to feed
    localparam int PAUSE        = 10;    // idle cycles before a register write
    localparam int TAIL         = 20;    // quiet cycles before the verdict
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 4000;  // watchdog: cycles with no beat at all

    localparam mix_row_t DIR_ROWS [12] = '{
        // mode 0: nothing selected, both sample extremes go in
        '{MIX_ZERO,  32'h0001_0000, 8'd2,   7'd2,   8'd2,  16'sd32767,  16'sd1,
          1'b1, 16'sd0, 1'b0},
        // plain diagonal, unity gain, extremes pass through
        '{MIX_DIAG,  32'h0001_0000, 8'd2,   7'd2,   8'd2,  16'sd32767,  16'sd1,
          1'b0, 16'sd0, 1'b0},
        // largest gain on the largest sample: clamps high
        '{MIX_HALF,  32'h7FFF_FFFF, 8'd2,   7'd1,   8'd2,  16'sd32767,  16'sd0,
          1'b1, 16'sd32767, 1'b1},
        // most negative gain: clamps to -32768
        '{MIX_HALF,  32'h8000_0000, 8'd2,   7'd1,   8'd2,  16'sd32767,  16'sd0,
          1'b1, -16'sd32768, 1'b1},
        // -1.0 times -32768 is one past the top
        '{MIX_HALF,  32'hFFFF_0000, 8'd2,   7'd1,   8'd2,  -16'sd32768, 16'sd0,
          1'b1, 16'sd32767, 1'b1},
        // 0.5 * -3 truncates toward zero
        '{MIX_HALF,  32'h0000_8000, 8'd2,   7'd1,   8'd2,  -16'sd3,     16'sd0,
          1'b1, -16'sd1, 1'b0},
        // zero channel counts act as one
        '{MIX_DIAG,  32'h0001_0000, 8'd0,   7'd0,   8'd1,  16'sd1234,   16'sd0,
          1'b1, 16'sd1234, 1'b0},
        // out count above the maximum saturates at 64
        '{MIX_DIAG,  32'h0001_0000, 8'd1,   7'd127, 8'd1,  -16'sd5,     16'sd0,
          1'b0, 16'sd0, 1'b0},
        // single output in multi mode: zero stride repeats one diagonal
        '{MIX_MULTI, 32'h0001_0000, 8'd3,   7'd1,   8'd3,  16'sd100,    16'sd50,
          1'b0, 16'sd0, 1'b0},
        '{MIX_MULTI, 32'h0001_8000, 8'd4,   7'd2,   8'd4,  -16'sd7,     16'sd3,
          1'b0, 16'sd0, 1'b0},
        // shrink mid-vector: three of four samples, then N drops to two
        // and the next sample closes the vector at once
        '{MIX_DIAG,  32'h0001_0000, 8'd4,   7'd2,   8'd3,  16'sd10,     16'sd10,
          1'b0, 16'sd0, 1'b0},
        '{MIX_DIAG,  32'h0001_0000, 8'd2,   7'd2,   8'd1,  16'sd40,     16'sd0,
          1'b0, 16'sd0, 1'b0}
    };

    // ------------------------------------------------------------------
    // DUT signals; the bench-driven inputs are known from time zero
    // ------------------------------------------------------------------
    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [GAIN_W-1:0]    cfg_data       = '0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    smp_t                 sample         = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    smp_t                 out_value;
    logic [ROW_W-1:0]     out_channel;
    logic                 clipped;
    logic                 last_of_vector;

    gain_matrix_vector_mixer_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_value      (out_value),
        .out_channel    (out_channel),
        .clipped        (clipped),
        .last_of_vector (last_of_vector)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Mixer model: settings as last written, its own copy of the sample
    // store, and the queue of result beats still owed by the core
    // ------------------------------------------------------------------
    mix_mode_e          cur_mode   = MIX_ZERO;
    logic [GAIN_W-1:0]  cur_gain   = 32'h0001_0000;
    logic [N_W-1:0]     cur_n_raw  = 8'd128;
    logic [M_W-1:0]     cur_m_raw  = 7'd64;
    smp_t               store_copy [MAX_IN_CHANNELS];
    int                 fill_copy  = 0;
    mix_result_t        mix_results_q [$];

    // directed rows may pin value and clip of every result of a vector
    logic               typed_on    = 1'b0;
    smp_t               typed_value = '0;
    logic               typed_clip  = 1'b0;

    int                 err_count     = 0;
    int                 fed_items     = 0;
    int                 snd_idle_pct  = 0;
    int                 rcv_stall_pct = 0;
    int                 hold_req      = 0;   // bumped by the sequence
    int                 hold_ack      = 0;   // caught up by the receiver
    int                 hold_left     = 0;
    int                 quiet_cycles  = 0;

    // zero counts act as one, oversized counts clamp at the maximum
    function automatic int eff_in(input logic [N_W-1:0] raw);
        if (raw == 0)
            return 1;
        return (raw > MAX_IN_CHANNELS) ? MAX_IN_CHANNELS : int'(raw);
    endfunction

    function automatic int eff_out(input logic [M_W-1:0] raw);
        if (raw == 0)
            return 1;
        return (raw > MAX_OUT_CHANNELS) ? MAX_OUT_CHANNELS : int'(raw);
    endfunction

    // Is matrix entry (row, col) set? Diagonals are walked over the flat
    // index row*N+col; multi mode adds copies shifted by M/2 per step for
    // as long as step*M < N. Half mode takes columns below N/2.
    function automatic logic tap_set(input int row, input int col,
                                     input int n, input int m);
        int flat;
        int shift;
        int d;
        int rem;
        logic multi;
        flat  = row * n + col;
        multi = (cur_mode == MIX_MULTI);
        case (cur_mode)
            MIX_DIAG, MIX_MULTI:
            begin
                for (d = 0; d == 0 || (multi && d * m < n); d++)
                begin
                    shift = (m / 2) * d;
                    if (shift > flat)
                        break;
                    rem = flat - shift;
                    if (rem % (n + 1) == 0 && rem / (n + 1) < m)
                        return 1'b1;
                end
                return 1'b0;
            end
            MIX_HALF:
                return col < n / 2;
            default:
                return 1'b0;
        endcase
    endfunction

    // Store one accepted sample; when the vector fills, queue its M results.
    task automatic take_sample(input smp_t s);
        int n;
        int m;
        int j;
        int col;
        longint acc;
        longint v;
        mix_result_t r;
        n = eff_in(cur_n_raw);
        m = eff_out(cur_m_raw);
        if (fill_copy < MAX_IN_CHANNELS)
            store_copy[fill_copy] = s;
        fill_copy++;
        if (fill_copy < n)
            return;
        fill_copy = 0;
        for (j = 0; j < m; j++)
        begin
            acc = 0;
            for (col = 0; col < n; col++)
                if (tap_set(j, col, n, m))
                    acc += store_copy[col];
            // Q16.16 gain, exact product, division truncates toward zero
            v = (acc * longint'(signed'(cur_gain))) / 65536;
            r.clip = 1'b0;
            if (v > OUT_MAX)
            begin
                v      = OUT_MAX;
                r.clip = 1'b1;
            end
            else if (v < OUT_MIN)
            begin
                v      = OUT_MIN;
                r.clip = 1'b1;
            end
            r.value = v[SAMPLE_W-1:0];
            r.chan  = j[ROW_W-1:0];
            r.last  = (j == m - 1);
            if (typed_on)
            begin
                r.value = typed_value;
                r.clip  = typed_clip;
            end
            mix_results_q.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check every accepted beat, drive out_stall. A pending
    // hold request turns into solid stall until hold_left, loaded with HOLD_CYCLES, runs out.
    // ------------------------------------------------------------------
    task automatic check_result();
        mix_result_t want;
        mix_result_t got;
        got = '{out_value, out_channel, clipped, last_of_vector};
        if (mix_results_q.size() == 0)
        begin
            err_count++;
            $display("%0t: unexpected beat: value %0d chan %0d clip %0b last %0b",
                     $time, got.value, got.chan, got.clip, got.last);
            return;
        end
        want = mix_results_q.pop_front();
        if (got !== want)
        begin
            err_count++;
            $display("%0t: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                     $time, want.value, want.chan, want.clip, want.last,
                     got.value, got.chan, got.clip, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_result();
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // watchdog: a run that stops moving beats is a failure
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_gain_matrix_vector_mixer_core: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer each sample as a beat, hold it while stalled. Idle gaps only
    // fall between beats, so valid never reacts to stall.
    task automatic send_samples(input smp_t q[$]);
        int i;
        i = 0;
        while (i < q.size())
        begin
            if ($urandom_range(99) < snd_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                in_valid <= 1'b1;
                sample   <= q[i];
                @(posedge clk);
                while (in_stall)
                    @(posedge clk);
                take_sample(q[i]);
                i++;
            end
        end
        in_valid <= 1'b0;
    endtask

    // wait out every owed result, then give the core time to go idle
    task automatic settle();
        while (mix_results_q.size() != 0)
            @(posedge clk);
        repeat (PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_e idx, input logic [GAIN_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // all four registers; unused upper data bits carry junk
    task automatic load_settings(input mix_mode_e mode, input logic [31:0] gain,
                                 input logic [N_W-1:0] n_raw,
                                 input logic [M_W-1:0] m_raw);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_MODE,   {junk[31:MODE_W], mode});
        write_reg(REG_GAIN,   gain);
        write_reg(REG_IN_CH,  {junk[31:N_W] ^ junk[31-N_W:0], n_raw});
        write_reg(REG_OUT_CH, {junk[31:M_W], m_raw});
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_mode  = mode;
        cur_gain  = gain;
        cur_n_raw = n_raw;
        cur_m_raw = m_raw;
    endtask

    task automatic set_profile(input int profile);
        case (profile)
            1:       begin snd_idle_pct = 76; rcv_stall_pct = 0;  end
            2:       begin snd_idle_pct = 0;  rcv_stall_pct = 76; end
            3:       begin snd_idle_pct = 18; rcv_stall_pct = 18; end
            default: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        endcase
    endtask

    // one random phase: settings, then whole vectors of random samples
    task automatic run_phase(input int profile, input mix_mode_e mode,
                             input logic [31:0] gain, input logic [N_W-1:0] n_raw,
                             input logic [M_W-1:0] m_raw, input int vectors,
                             input logic squeeze);
        smp_t q[$];
        int k;
        settle();
        set_profile(profile);
        load_settings(mode, gain, n_raw, m_raw);
        if (squeeze)
            hold_req++;
        for (k = 0; k < vectors * eff_in(n_raw); k++)
        begin
            // extremes, values near zero, full range
            case ($urandom_range(9))
                0:       q.push_back(16'sd32767);
                1:       q.push_back(-16'sd32768);
                2, 3, 4: q.push_back(smp_t'($urandom_range(200) - 100));
                default: q.push_back(smp_t'($urandom));
            endcase
        end
        send_samples(q);
        fed_items += q.size();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        mix_row_t    row;
        smp_t        q[$];
        int          r;
        int          k;
        int          phase;
        logic [31:0] gain;
        logic [N_W-1:0] n_raw;
        logic [M_W-1:0] m_raw;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling; the first vector is small so only
        // freshly written store entries are ever summed
        for (r = 0; r < 12; r++)
        begin
            row = DIR_ROWS[r];
            settle();
            set_profile(0);
            load_settings(row.mode, row.gain, row.n_raw, row.m_raw);
            typed_on    = row.typed;
            typed_value = row.exp_value;
            typed_clip  = row.exp_clip;
            q.delete();
            for (k = 0; k < row.count; k++)
                q.push_back(smp_t'(row.first + row.incr * k));
            send_samples(q);
        end
        typed_on = 1'b0;

        // receiver holds off while the sender keeps offering: input fills
        // and in_stall has to hold the beats back
        run_phase(0, MIX_HALF, 32'h0001_0000, 8'd4, 7'd4, 5, 1'b1);

        // one vector at the largest sizes, counts written at or above the maximum
        run_phase(2, mix_mode_e'($urandom_range(3)), $urandom,
                  N_W'($urandom_range(128, 255)), M_W'($urandom_range(64, 127)),
                  1, 1'b0);

        // random phases, cycling through the idle profiles
        phase = 0;
        while (fed_items < ITEMS)
        begin
            case ($urandom_range(7))
                0:       gain = 32'h7FFF_FFFF;
                1:       gain = 32'h8000_0000;
                2:       gain = 32'h0;
                3, 4:    gain = $urandom;
                default: gain = $urandom_range(32'h3_FFFF) - 32'h2_0000;
            endcase
            k = $urandom_range(9);
            n_raw = (k == 0) ? N_W'(0) :
                    (k == 1) ? N_W'($urandom_range(13, 40)) : N_W'($urandom_range(1, 12));
            k = $urandom_range(9);
            m_raw = (k == 0) ? M_W'(0) :
                    (k == 1) ? M_W'($urandom_range(13, 127)) : M_W'($urandom_range(1, 12));
            run_phase(phase % 4, mix_mode_e'($urandom_range(3)), gain, n_raw, m_raw,
                      $urandom_range(1, 4), 1'b0);
            phase++;
        end

        while (mix_results_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (err_count == 0)
            $display("tb_gain_matrix_vector_mixer_core: clean");
        else
            $display("tb_gain_matrix_vector_mixer_core: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/gmvm_pkg.sv
hdl/gmvm_mac.sv
hdl/gain_matrix_vector_mixer_core.sv
bench/tb_gain_matrix_vector_mixer_core.sv
